// ===== rtl/twg_pkg.sv =====
// Shared widths, register map, bus structs and saturation helper of the twiddle gain tuner.
`timescale 1ns / 1ps

package twg_pkg;

    localparam int GAIN_COUNT = 3;
    localparam int INIT_COUNT = (GAIN_COUNT < 3) ? GAIN_COUNT : 3;
    localparam int GIDX_W     = (GAIN_COUNT > 1) ? $clog2(GAIN_COUNT) : 1;
    localparam int SWC_W      = $clog2(GAIN_COUNT + 1);

    localparam int ERR_W      = 16;
    localparam int SQ_CNT_W   = $clog2(ERR_W);
    localparam int SQ_W       = 2 * ERR_W;
    localparam int SUM_W      = 46;
    localparam int MEAN_W     = 30;
    localparam int GAIN_W     = 32;
    localparam int STEP_W     = 31;
    localparam int PROD_W     = STEP_W + 4;
    localparam int SSUM_W     = STEP_W + GIDX_W;
    localparam int CNT_W      = 16;
    localparam int DIV_N_W    = SUM_W;
    localparam int DIV_D_W    = CNT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_N_W);

    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic [2:0] REG_TOLERANCE = 3'd0;
    localparam logic [2:0] REG_PERIOD    = 3'd1;
    localparam logic [2:0] REG_GAIN0     = 3'd2;
    localparam logic [2:0] REG_GAIN1     = 3'd3;
    localparam logic [2:0] REG_GAIN2     = 3'd4;
    localparam logic [2:0] REG_STEP0     = 3'd5;
    localparam logic [2:0] REG_STEP1     = 3'd6;
    localparam logic [2:0] REG_STEP2     = 3'd7;

    localparam logic [STEP_W-1:0] TOL_RST    = 31'd13107;
    localparam logic [CNT_W-1:0]  PERIOD_RST = 16'd100;
    localparam logic [STEP_W-1:0] STEP_RST   = 31'd65536;

    localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};
    localparam logic [STEP_W-1:0] STEP_MAX = {STEP_W{1'b1}};
    localparam logic [DIV_D_W-1:0] TEN     = 16'd10;

    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic signed [GAIN_W-1:0] gain_t;
    typedef logic [STEP_W-1:0]        step_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } div_rsp_t;

    function automatic gain_t sat_gain(input logic [GAIN_W+1:0] v);
        gain_t r;
        if (v[GAIN_W+1:GAIN_W-1] == 3'b000 || v[GAIN_W+1:GAIN_W-1] == 3'b111)
        begin
            r = v[GAIN_W-1:0];
        end
        else if (v[GAIN_W+1])
        begin
            r = {1'b1, {(GAIN_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(GAIN_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== rtl/twg_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module twg_div (
    input  logic             clk,
    input  logic             rst_n,
    input  twg_pkg::div_req_t req,
    output twg_pkg::div_rsp_t rsp
);
    import twg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   den_reg, den_next;

    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W+1:0]   diff;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[DIV_N_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = !diff[DIV_D_W+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== rtl/twiddle_gain_tuner.sv =====
// Twiddle coordinate-descent tuner of three controller gains driven by error samples.
`timescale 1ns / 1ps

// Takes one track_error sample per transaction and returns one result transaction with
// the current gains, a trial_ended flag and a converged flag. A sample that does not
// close a period passes through bit-serial squaring, an accumulate state, the output
// state and idle before the next acceptance. A sample that closes a period adds a wait
// on the serial division of the squared sum by the period length (the quotient bits and
// a done strobe) and a decide state, after which a converged tuner answers. A baseline trial
// adds the probe and a step-sum sweep; a downward probe adds only the sweep. When a step
// grows or shrinks, a second division by ten, a gain-index state, the probe and the
// sweep follow. The output register lets the next sample enter while a result waits;
// a second waiting result holds the block in its output state. Every register write
// restarts tuning from the registers once the tuner is idle; while the restart is
// pending, track_ready is low.
module twiddle_gain_tuner (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [twg_pkg::ADDR_W-1:0]   paddr,
    input  logic [twg_pkg::DATA_W-1:0]   pwdata,
    output logic [twg_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         track_valid,
    output logic                         track_ready,
    input  twg_pkg::err_t                track_error,
    output logic                         result_valid,
    input  logic                         result_ready,
    output twg_pkg::gain_t               gain0,
    output twg_pkg::gain_t               gain1,
    output twg_pkg::gain_t               gain2,
    output logic                         trial_ended,
    output logic                         converged
);
    import twg_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQ     = 4'd1;
    localparam logic [3:0] ST_ACC    = 4'd2;
    localparam logic [3:0] ST_DIVM   = 4'd3;
    localparam logic [3:0] ST_DECIDE = 4'd4;
    localparam logic [3:0] ST_DIVS   = 4'd5;
    localparam logic [3:0] ST_NEXT   = 4'd6;
    localparam logic [3:0] ST_PROBE  = 4'd7;
    localparam logic [3:0] ST_SWEEP  = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    // configuration
    step_t            tol_reg;
    logic [CNT_W-1:0] period_reg;
    gain_t            gain_init_reg [3];
    step_t            step_init_reg [3];
    logic             restart_reg, restart_next;
    logic             cfg_wr;

    // tuner state
    logic [3:0]        state_reg, state_next;
    gain_t             gains_reg [GAIN_COUNT];
    gain_t             gains_next [GAIN_COUNT];
    step_t             steps_reg [GAIN_COUNT];
    step_t             steps_next [GAIN_COUNT];
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sqsum_reg, sqsum_next;
    logic [MEAN_W-1:0] best_reg, best_next;
    logic              have_reg, have_next;
    logic [GIDX_W-1:0] gidx_reg, gidx_next;
    logic              up_reg, up_next;
    logic              grow_reg, grow_next;
    logic              over_reg, over_next;
    logic              ended_reg, ended_next;
    logic              conv_reg, conv_next;
    logic [SWC_W-1:0]  swc_reg, swc_next;
    logic [SSUM_W-1:0] ssum_reg, ssum_next;

    // serial squarer and datapath payload
    logic [SQ_CNT_W-1:0] sqc_reg, sqc_next;
    logic [ERR_W-1:0]    mcand_reg, mcand_next;
    logic [SQ_W-1:0]     prod_reg, prod_next;
    logic [MEAN_W-1:0]   mean_reg, mean_next;

    // result register
    logic  rvalid_reg, rvalid_next;
    gain_t rgain_reg [3];
    logic  rended_reg;
    logic  rconv_reg;
    logic  out_load;
    gain_t gout [3];

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [GIDX_W-1:0]  rd_idx;
    step_t              step_rd;
    gain_t              gain_rd;
    logic [ERR_W-1:0]   err_mag;
    logic [ERR_W:0]     sq_add;
    logic [SUM_W-1:0]   sum_new;
    logic [CNT_W-1:0]   count_inc;
    logic [CNT_W-1:0]   period_eff;
    logic [PROD_W-1:0]  step_ext;
    logic [PROD_W-1:0]  step_x11;
    logic [PROD_W-1:0]  step_x9;
    logic [GAIN_W+1:0]  gain_ext;
    logic [GAIN_W+1:0]  gain_plus;
    logic [GAIN_W+1:0]  gain_minus2;
    logic [GIDX_W:0]    gidx_inc;
    logic               ssum_over;

    twg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[4:2])
            REG_TOLERANCE: prdata = {1'b0, tol_reg};
            REG_PERIOD:    prdata = {{(DATA_W-CNT_W){1'b0}}, period_reg};
            REG_GAIN0:     prdata = gain_init_reg[0];
            REG_GAIN1:     prdata = gain_init_reg[1];
            REG_GAIN2:     prdata = gain_init_reg[2];
            REG_STEP0:     prdata = {1'b0, step_init_reg[0]};
            REG_STEP1:     prdata = {1'b0, step_init_reg[1]};
            REG_STEP2:     prdata = {1'b0, step_init_reg[2]};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= TOL_RST;
            period_reg <= PERIOD_RST;
            for (int i = 0; i < 3; i++)
            begin
                gain_init_reg[i] <= '0;
                step_init_reg[i] <= STEP_RST;
            end
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_TOLERANCE: tol_reg          <= pwdata[STEP_W-1:0];
                REG_PERIOD:    period_reg       <= pwdata[CNT_W-1:0];
                REG_GAIN0:     gain_init_reg[0] <= pwdata;
                REG_GAIN1:     gain_init_reg[1] <= pwdata;
                REG_GAIN2:     gain_init_reg[2] <= pwdata;
                REG_STEP0:     step_init_reg[0] <= pwdata[STEP_W-1:0];
                REG_STEP1:     step_init_reg[1] <= pwdata[STEP_W-1:0];
                REG_STEP2:     step_init_reg[2] <= pwdata[STEP_W-1:0];
                default:       tol_reg          <= tol_reg;
            endcase
        end
    end

    // shared datapath
    assign rd_idx      = (state_reg == ST_SQ || state_reg == ST_SWEEP)
                         ? swc_reg[GIDX_W-1:0] : gidx_reg;
    assign step_rd     = steps_reg[rd_idx];
    assign gain_rd     = gains_reg[gidx_reg];
    assign err_mag     = track_error[ERR_W-1] ? (~track_error + ERR_W'(1)) : track_error;
    assign sq_add      = {1'b0, prod_reg[SQ_W-1:ERR_W]}
                         + (prod_reg[0] ? {1'b0, mcand_reg} : {(ERR_W+1){1'b0}});
    assign sum_new     = sqsum_reg + {{(SUM_W-SQ_W){1'b0}}, prod_reg};
    assign count_inc   = count_reg + CNT_W'(1);
    assign period_eff  = (period_reg == '0) ? CNT_W'(1) : period_reg;
    assign step_ext    = {{(PROD_W-STEP_W){1'b0}}, step_rd};
    assign step_x11    = (step_ext << 3) + (step_ext << 1) + step_ext;
    assign step_x9     = (step_ext << 3) + step_ext;
    assign gain_ext    = {{2{gain_rd[GAIN_W-1]}}, gain_rd};
    assign gain_plus   = gain_ext + {3'b000, step_rd};
    assign gain_minus2 = gain_ext - {2'b00, step_rd, 1'b0};
    assign gidx_inc    = {1'b0, gidx_reg} + (GIDX_W+1)'(1);
    assign ssum_over   = ssum_reg > {{(SSUM_W-STEP_W){1'b0}}, tol_reg};

    assign track_ready = (state_reg == ST_IDLE) && !restart_reg;
    assign out_load    = (state_reg == ST_OUT) && (!rvalid_reg || result_ready);

    always_comb
    begin
        state_next   = state_reg;
        restart_next = restart_reg;
        gains_next   = gains_reg;
        steps_next   = steps_reg;
        count_next   = count_reg;
        sqsum_next   = sqsum_reg;
        best_next    = best_reg;
        have_next    = have_reg;
        gidx_next    = gidx_reg;
        up_next      = up_reg;
        grow_next    = grow_reg;
        over_next    = over_reg;
        ended_next   = ended_reg;
        conv_next    = conv_reg;
        swc_next     = swc_reg;
        ssum_next    = ssum_reg;
        sqc_next     = sqc_reg;
        mcand_next   = mcand_reg;
        prod_next    = prod_reg;
        mean_next    = mean_reg;
        div_req      = '0;

        if (cfg_wr)
        begin
            restart_next = 1'b1;
        end

        // step sum sweep, shared by squaring and the final check
        if ((state_reg == ST_SQ || state_reg == ST_SWEEP) && swc_reg < SWC_W'(GAIN_COUNT))
        begin
            ssum_next = ssum_reg + {{(SSUM_W-STEP_W){1'b0}}, step_rd};
            swc_next  = swc_reg + SWC_W'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (restart_reg)
                begin
                    for (int i = 0; i < GAIN_COUNT; i++)
                    begin
                        gains_next[i] = '0;
                        steps_next[i] = '0;
                    end
                    for (int i = 0; i < INIT_COUNT; i++)
                    begin
                        gains_next[i] = gain_init_reg[i];
                        steps_next[i] = step_init_reg[i];
                    end
                    count_next = '0;
                    sqsum_next = '0;
                    best_next  = '0;
                    have_next  = 1'b0;
                    gidx_next  = '0;
                    up_next    = 1'b1;
                    if (!cfg_wr)
                    begin
                        restart_next = 1'b0;
                    end
                end
                else if (track_valid)
                begin
                    mcand_next = err_mag;
                    prod_next  = {{(SQ_W-ERR_W){1'b0}}, err_mag};
                    sqc_next   = '0;
                    swc_next   = '0;
                    ssum_next  = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                prod_next = {sq_add, prod_reg[ERR_W-1:1]};
                sqc_next  = sqc_reg + SQ_CNT_W'(1);
                if (sqc_reg == SQ_CNT_W'(ERR_W - 1))
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                over_next = ssum_over;
                if (count_inc >= period_eff)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = sum_new;
                    div_req.divisor  = period_eff;
                    sqsum_next       = '0;
                    count_next       = '0;
                    state_next       = ST_DIVM;
                end
                else
                begin
                    sqsum_next = sum_new;
                    count_next = count_inc;
                    ended_next = 1'b0;
                    conv_next  = !ssum_over;
                    state_next = ST_OUT;
                end
            end
            ST_DIVM:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient > {{(DIV_N_W-MEAN_W){1'b0}}, MEAN_MAX})
                    begin
                        mean_next = MEAN_MAX;
                    end
                    else
                    begin
                        mean_next = div_rsp.quotient[MEAN_W-1:0];
                    end
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!over_reg)
                begin
                    ended_next = 1'b0;
                    conv_next  = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    ended_next = 1'b1;
                    if (!have_reg)
                    begin
                        best_next  = mean_reg;
                        have_next  = 1'b1;
                        state_next = ST_PROBE;
                    end
                    else if (mean_reg < best_reg)
                    begin
                        best_next        = mean_reg;
                        grow_next        = 1'b1;
                        div_req.start    = 1'b1;
                        div_req.dividend = {{(DIV_N_W-PROD_W){1'b0}}, step_x11};
                        div_req.divisor  = TEN;
                        state_next       = ST_DIVS;
                    end
                    else if (up_reg)
                    begin
                        gains_next[gidx_reg] = sat_gain(gain_minus2);
                        up_next              = 1'b0;
                        swc_next             = '0;
                        ssum_next            = '0;
                        state_next           = ST_SWEEP;
                    end
                    else
                    begin
                        gains_next[gidx_reg] = sat_gain(gain_plus);
                        grow_next            = 1'b0;
                        div_req.start        = 1'b1;
                        div_req.dividend     = {{(DIV_N_W-PROD_W){1'b0}}, step_x9};
                        div_req.divisor      = TEN;
                        state_next           = ST_DIVS;
                    end
                end
            end
            ST_DIVS:
            begin
                if (div_rsp.done)
                begin
                    if (grow_reg &&
                        div_rsp.quotient > {{(DIV_N_W-STEP_W){1'b0}}, STEP_MAX})
                    begin
                        steps_next[gidx_reg] = STEP_MAX;
                    end
                    else
                    begin
                        steps_next[gidx_reg] = div_rsp.quotient[STEP_W-1:0];
                    end
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (gidx_inc >= (GIDX_W+1)'(GAIN_COUNT))
                begin
                    gidx_next = '0;
                end
                else
                begin
                    gidx_next = gidx_inc[GIDX_W-1:0];
                end
                up_next    = 1'b1;
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                gains_next[gidx_reg] = sat_gain(gain_plus);
                swc_next             = '0;
                ssum_next            = '0;
                state_next           = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (swc_reg == SWC_W'(GAIN_COUNT))
                begin
                    conv_next  = !ssum_over;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            gout[i] = '0;
        end
        for (int i = 0; i < INIT_COUNT; i++)
        begin
            gout[i] = gains_reg[i];
        end
    end

    always_comb
    begin
        rvalid_next = rvalid_reg;
        if (out_load)
        begin
            rvalid_next = 1'b1;
        end
        else if (result_ready)
        begin
            rvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            restart_reg <= 1'b0;
            for (int i = 0; i < GAIN_COUNT; i++)
            begin
                gains_reg[i] <= '0;
                steps_reg[i] <= '0;
            end
            for (int i = 0; i < INIT_COUNT; i++)
            begin
                steps_reg[i] <= STEP_RST;
            end
            count_reg   <= '0;
            sqsum_reg   <= '0;
            best_reg    <= '0;
            have_reg    <= 1'b0;
            gidx_reg    <= '0;
            up_reg      <= 1'b1;
            grow_reg    <= 1'b0;
            over_reg    <= 1'b0;
            ended_reg   <= 1'b0;
            conv_reg    <= 1'b0;
            swc_reg     <= '0;
            sqc_reg     <= '0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            restart_reg <= restart_next;
            gains_reg   <= gains_next;
            steps_reg   <= steps_next;
            count_reg   <= count_next;
            sqsum_reg   <= sqsum_next;
            best_reg    <= best_next;
            have_reg    <= have_next;
            gidx_reg    <= gidx_next;
            up_reg      <= up_next;
            grow_reg    <= grow_next;
            over_reg    <= over_next;
            ended_reg   <= ended_next;
            conv_reg    <= conv_next;
            swc_reg     <= swc_next;
            sqc_reg     <= sqc_next;
            rvalid_reg  <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ssum_reg  <= ssum_next;
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
        mean_reg  <= mean_next;
        if (out_load)
        begin
            rgain_reg  <= gout;
            rended_reg <= ended_reg;
            rconv_reg  <= conv_reg;
        end
    end

    assign result_valid = rvalid_reg;
    assign gain0        = rgain_reg[0];
    assign gain1        = rgain_reg[1];
    assign gain2        = rgain_reg[2];
    assign trial_ended  = rended_reg;
    assign converged    = rconv_reg;

`ifndef SYNTH
    a_gidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, gidx_reg} < (GIDX_W+1)'(GAIN_COUNT))
        else $error("gain index out of range");

    a_accept_squares: assert property (@(posedge clk) disable iff (!rst_n)
        (track_valid && track_ready) |=> state_reg == ST_SQ)
        else $error("accepted transaction did not start squaring");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (result_valid && state_reg == ST_IDLE))
        else $error("result load did not raise result_valid");
`endif

endmodule

// ===== tb/twg_checker.sv =====
// Checker of the twiddle gain tuner: predicts every result from samples and register writes.
`timescale 1ns / 1ps

module twg_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [twg_pkg::ADDR_W-1:0]   paddr,
    input  logic [twg_pkg::DATA_W-1:0]   pwdata,
    input  logic                         pready,
    input  logic                         track_valid,
    input  logic                         track_ready,
    input  twg_pkg::err_t                track_error,
    input  logic                         result_valid,
    input  logic                         result_ready,
    input  twg_pkg::gain_t               gain0,
    input  twg_pkg::gain_t               gain1,
    input  twg_pkg::gain_t               gain2,
    input  logic                         trial_ended,
    input  logic                         converged,
    output int                           mismatch_count,
    output int                           results_pending
);

    import twg_pkg::*;

    localparam longint GAIN_TOP    = 64'sd2147483647;
    localparam longint GAIN_BOTTOM = -64'sd2147483648;
    localparam int     PRINT_LIMIT = 100;

    typedef struct packed {
        gain_t gain0;
        gain_t gain1;
        gain_t gain2;
        logic  ended;
        logic  settled;
    } gain_report_t;

    gain_report_t       gain_report_q [$];
    gain_report_t       fresh_report;

    step_t              tol_cfg;
    logic [CNT_W-1:0]   period_cfg;
    gain_t              gain_start [3];
    step_t              step_start [3];

    gain_t              gain_now [GAIN_COUNT];
    step_t              step_now [GAIN_COUNT];
    logic [CNT_W-1:0]   samples_seen;
    logic [SUM_W-1:0]   error_energy;
    logic [MEAN_W-1:0]  best_mean;
    logic               baseline_taken;
    int unsigned        active_gain;
    logic               probing_up;

    function automatic gain_t clamp_gain(input longint v);
        if (v > GAIN_TOP)
        begin
            return gain_t'(GAIN_TOP);
        end
        if (v < GAIN_BOTTOM)
        begin
            return gain_t'(GAIN_BOTTOM);
        end
        return gain_t'(v);
    endfunction

    function automatic longint unsigned step_total();
        longint unsigned s;
        s = 0;
        for (int i = 0; i < GAIN_COUNT; i++)
        begin
            s += step_now[i];
        end
        return s;
    endfunction

    function automatic gain_t shown_gain(input int i);
        return (i < GAIN_COUNT) ? gain_now[i] : '0;
    endfunction

    task automatic restart_tuning();
        for (int i = 0; i < GAIN_COUNT; i++)
        begin
            gain_now[i] = (i < 3) ? gain_start[i] : '0;
            step_now[i] = (i < 3) ? step_start[i] : '0;
        end
        samples_seen   = '0;
        error_energy   = '0;
        best_mean      = '0;
        baseline_taken = 1'b0;
        active_gain    = 0;
        probing_up     = 1'b1;
    endtask

    task automatic probe_up();
        gain_now[active_gain] = clamp_gain(longint'(gain_now[active_gain])
                                           + longint'(step_now[active_gain]));
    endtask

    task automatic move_to_next_gain();
        active_gain = (active_gain + 1 >= GAIN_COUNT) ? 0 : active_gain + 1;
        probing_up  = 1'b1;
        probe_up();
    endtask

    task automatic apply_write(input logic [2:0] sel, input logic [DATA_W-1:0] value);
        case (sel) inside
            REG_TOLERANCE: tol_cfg = value[STEP_W-1:0];
            REG_PERIOD:    period_cfg = value[CNT_W-1:0];
            REG_GAIN0, REG_GAIN1, REG_GAIN2: gain_start[sel - REG_GAIN0] = value;
            default:       step_start[sel - REG_STEP0] = value[STEP_W-1:0];
        endcase
        restart_tuning();
    endtask

    task automatic advance_twiddle(input err_t err, output gain_report_t rep);
        longint unsigned period;
        longint unsigned mean;
        longint unsigned grown;
        logic            ended;
        ended        = 1'b0;
        period       = (period_cfg == 0) ? 1 : period_cfg;
        error_energy = error_energy + SUM_W'(longint'(err) * longint'(err));
        samples_seen = samples_seen + 1'b1;
        if (samples_seen >= period)
        begin
            mean = error_energy / period;
            if (mean > MEAN_MAX)
            begin
                mean = MEAN_MAX;
            end
            if (step_total() > tol_cfg)
            begin
                ended = 1'b1;
                if (!baseline_taken)
                begin
                    best_mean      = MEAN_W'(mean);
                    baseline_taken = 1'b1;
                    probe_up();
                end
                else if (mean < best_mean)
                begin
                    grown     = longint'(step_now[active_gain]) * 11 / 10;
                    best_mean = MEAN_W'(mean);
                    step_now[active_gain] = (grown > STEP_MAX) ? STEP_MAX : step_t'(grown);
                    move_to_next_gain();
                end
                else if (probing_up)
                begin
                    gain_now[active_gain] = clamp_gain(longint'(gain_now[active_gain])
                                                       - 2 * longint'(step_now[active_gain]));
                    probing_up = 1'b0;
                end
                else
                begin
                    gain_now[active_gain] = clamp_gain(longint'(gain_now[active_gain])
                                                       + longint'(step_now[active_gain]));
                    step_now[active_gain] = step_t'(longint'(step_now[active_gain]) * 9 / 10);
                    move_to_next_gain();
                end
            end
            samples_seen = '0;
            error_energy = '0;
        end
        rep.gain0   = shown_gain(0);
        rep.gain1   = shown_gain(1);
        rep.gain2   = shown_gain(2);
        rep.ended   = ended;
        rep.settled = (step_total() <= tol_cfg);
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("%0t mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    task automatic check_result();
        gain_report_t want;
        if (gain_report_q.size() == 0)
        begin
            report_mismatch("result transaction with no sample outstanding");
            return;
        end
        want = gain_report_q.pop_front();
        if (gain0 !== want.gain0)
        begin
            report_mismatch($sformatf("gain0 got %0d, want %0d", gain0, want.gain0));
        end
        if (gain1 !== want.gain1)
        begin
            report_mismatch($sformatf("gain1 got %0d, want %0d", gain1, want.gain1));
        end
        if (gain2 !== want.gain2)
        begin
            report_mismatch($sformatf("gain2 got %0d, want %0d", gain2, want.gain2));
        end
        if (trial_ended !== want.ended)
        begin
            report_mismatch($sformatf("trial_ended got %b, want %b", trial_ended, want.ended));
        end
        if (converged !== want.settled)
        begin
            report_mismatch($sformatf("converged got %b, want %b", converged, want.settled));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_cfg    = TOL_RST;
            period_cfg = PERIOD_RST;
            for (int i = 0; i < 3; i++)
            begin
                gain_start[i] = '0;
                step_start[i] = STEP_RST;
            end
            restart_tuning();
            gain_report_q.delete();
            mismatch_count  = 0;
            results_pending = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                check_result();
            end
            if (psel && penable && pwrite && pready)
            begin
                apply_write(paddr[ADDR_W-1:2], pwdata);
            end
            if (track_valid && track_ready)
            begin
                advance_twiddle(track_error, fresh_report);
                gain_report_q.push_back(fresh_report);
            end
            results_pending = gain_report_q.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top of the twiddle gain tuner: clock, reset, register setup and sample traffic.
`timescale 1ns / 1ps

module tb_top;

    import twg_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_SAMPLES = 90;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               track_valid;
    logic               track_ready;
    err_t               track_error;
    logic               result_valid;
    logic               result_ready;
    gain_t              gain0;
    gain_t              gain1;
    gain_t              gain2;
    logic               trial_ended;
    logic               converged;

    int                 mismatch_count;
    int                 results_pending;
    int                 sender_idle_pct   = 29;
    int                 receiver_idle_pct = 70;
    logic               hold_request;
    int                 cycle_count;

    twiddle_gain_tuner i_dut (.*);

    twg_checker i_checker (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        result_ready = 1'b0;
        hold_request = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic write_register(input logic [2:0] index, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_tuner(input logic [DATA_W-1:0] tol, input logic [DATA_W-1:0] period,
                                 input logic [DATA_W-1:0] g0, input logic [DATA_W-1:0] g1,
                                 input logic [DATA_W-1:0] g2, input logic [DATA_W-1:0] s0,
                                 input logic [DATA_W-1:0] s1, input logic [DATA_W-1:0] s2);
        write_register(REG_TOLERANCE, tol);
        write_register(REG_PERIOD, period);
        write_register(REG_GAIN0, g0);
        write_register(REG_GAIN1, g1);
        write_register(REG_GAIN2, g2);
        write_register(REG_STEP0, s0);
        write_register(REG_STEP1, s1);
        write_register(REG_STEP2, s2);
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        @(posedge clk);
        sender_idle_pct   = sender_pct;
        receiver_idle_pct = receiver_pct;
        @(negedge clk);
    endtask

    task automatic send_sample(input err_t err);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            track_valid <= 1'b0;
            @(negedge clk);
        end
        track_valid <= 1'b1;
        track_error <= err;
        do @(posedge clk); while (!track_ready);
        @(negedge clk);
    endtask

    task automatic drain_results();
        track_valid <= 1'b0;
        while (results_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_tolerance();
        case ($urandom_range(4))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(400);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_period();
        case ($urandom_range(5))
            0:       return '0;
            1:       return $urandom_range(20, 5);
            default: return $urandom_range(4, 1);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(3))
            0:       return 32'h7FFF_FFFF - $urandom_range(255);
            1:       return 32'h8000_0000 + $urandom_range(255);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_step();
        case ($urandom_range(5))
            0:       return {1'b0, STEP_MAX};
            1:       return $urandom;
            2:       return '0;
            default: return $urandom_range(300);
        endcase
    endfunction

    function automatic err_t pick_error(input int shift_floor);
        err_t e;
        e = ERR_W'($urandom);
        return e >>> $urandom_range(15, shift_floor);
    endfunction

    initial
    begin
        int phase;
        int n;
        int trend;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        track_valid = 1'b0;
        track_error = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_idling(29, 70);
        program_tuner(32'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
                      {1'b0, STEP_MAX}, {1'b0, STEP_MAX}, 32'd0);
        send_sample(err_t'(16'h8000));
        send_sample(err_t'(16'h0000));
        send_sample(err_t'(16'h7FFF));
        send_sample(err_t'(16'h0001));
        send_sample(err_t'(16'hFFFF));
        send_sample(err_t'(16'h5555));
        send_sample(err_t'(16'hAAAA));
        send_sample(err_t'(16'h0000));
        drain_results();
        program_tuner(32'h7FFF_FFFF, 32'd1, 32'd5, 32'hFFFF_FFFB, 32'd0,
                      32'd100, 32'd100, 32'd100);
        send_sample(err_t'(16'h0100));
        send_sample(err_t'(16'h0010));
        send_sample(err_t'(16'h1000));
        drain_results();
        program_tuner(32'd0, 32'd3, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        send_sample(err_t'(16'h0200));
        send_sample(err_t'(16'hFE00));
        send_sample(err_t'(16'h0002));
        drain_results();
        program_tuner(32'd13107, 32'd65535, 32'd0, 32'd0, 32'd0,
                      32'd65536, 32'd65536, 32'd65536);
        send_sample(err_t'(16'h7FFF));
        send_sample(err_t'(16'h8000));
        send_sample(err_t'(16'h0001));
        drain_results();
        program_tuner(32'd0, 32'd2, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd1, 32'd2);
        send_sample(err_t'(16'd100));
        send_sample(err_t'(16'd100));
        send_sample(err_t'(16'd10));
        send_sample(err_t'(16'd10));
        send_sample(err_t'(16'd200));
        send_sample(err_t'(16'd200));
        send_sample(err_t'(16'd200));
        send_sample(err_t'(16'd200));

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_results();
            program_tuner(pick_tolerance(), pick_period(), pick_gain(), pick_gain(),
                          pick_gain(), pick_step(), pick_step(), pick_step());
            case (phase / 4)
                0:       set_idling(29, 70);
                1:       set_idling(70, 29);
                default: set_idling(0, 0);
            endcase
            trend = $urandom_range(1);
            for (n = 0; n < PHASE_SAMPLES; n++)
            begin
                if (n == 10 && (phase == 2 || phase == 9))
                begin
                    track_valid <= 1'b0;
                    @(posedge clk);
                    hold_request = 1'b1;
                    @(negedge clk);
                end
                send_sample(pick_error(trend ? (n * 15) / PHASE_SAMPLES : 0));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && results_pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
